// ===== sv/tree_distance_by_binary_lifting_macros.svh =====
// Assertion macros shared by the tree distance block.
`ifndef TREE_DISTANCE_BY_BINARY_LIFTING_MACROS_SVH
`define TREE_DISTANCE_BY_BINARY_LIFTING_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define TDBL_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define TDBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tdbl_pkg.sv =====
// Shared beat types and constants of the tree distance block.
package tdbl_pkg;

    localparam int FW = 10;

    localparam logic OP_ATTACH = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam int SENTINEL_NODE = 0;
    localparam int ROOT_NODE     = 1;

    localparam logic [FW-1:0] FIELD_MAX = 10'h3FF;

    typedef struct packed {
        logic          operation;
        logic [FW-1:0] node;
        logic [FW-1:0] other_node;
    } t_in_beat;

    typedef struct packed {
        logic [FW-1:0] distance;
        logic [FW-1:0] common_ancestor;
    } t_out_beat;

endpackage

// ===== sv/tdbl_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
interface tdbl_in_if import tdbl_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tdbl_out_if import tdbl_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tree_distance_by_binary_lifting.sv =====
// Attach: one dependent row read of the node memory per lift level.
// Query: one lift step per set bit of the depth difference; the difference has at
//   most min($clog2(NODE_COUNT), LIFT_LEVELS + 1) set bits.
// The lift and climb steps each wait on one read of the two-port row memory.
// One item is in flight at a time; a finished result sits in the output register while
//   the next item is taken. Reset clears control, then a clearing pass zeroes every row
//   before the first input beat is accepted.
`include "tree_distance_by_binary_lifting_macros.svh"

module tree_distance_by_binary_lifting import tdbl_pkg::*; #(
    parameter int NODE_COUNT  = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdbl_in_if.sink     i_in,
    tdbl_out_if.source  o_out
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(LIFT_LEVELS + 1);
    localparam int KW = LIFT_LEVELS + 1;
    localparam int XW = ((NW > FW) ? NW : FW) + 1;
    localparam int SW = (NW + 1 > FW) ? NW + 1 : FW;

    typedef logic [NW-1:0] t_node;

    // One row per node: depth and all ancestor levels.
    typedef struct packed {
        t_node                 depth;
        t_node [LIFT_LEVELS:0] anc;
    } t_row;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_ATT    = 10'b0000000100,
        S_ATT_WR = 10'b0000001000,
        S_QLOAD  = 10'b0000010000,
        S_LIFT   = 10'b0000100000,
        S_CLIMB  = 10'b0001000000,
        S_FIN    = 10'b0010000000,
        S_DEPTH  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_row r_mem [0:NODE_COUNT-1];
    t_row r_rd_a, r_rd_b;

    t_state        r_state, n_state;
    t_node         r_clr, n_clr;
    t_node         r_c, n_c;
    t_node         r_cur, n_cur;
    logic [LW-1:0] r_lvl, n_lvl;
    t_row          r_row, n_row;
    t_node         r_v, n_v;
    t_node         r_w, n_w;
    logic [KW-1:0] r_k, n_k;
    logic [NW:0]   r_sum, n_sum;
    t_node         r_lca, n_lca;
    t_out_beat     r_res, n_res;
    t_out_beat     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          w_we, w_re_a, w_re_b;
    t_node         w_wa, w_ra_a, w_ra_b;
    t_row          w_wd;

    logic [XW-1:0] w_a_x, w_b_x, w_lca_x;
    logic          w_a_ok, w_b_ok, w_att_ok;
    t_node         w_a, w_b;
    t_node         w_new, w_sat, w_lift;
    logic [LW-1:0] w_top;
    logic [NW:0]   w_twice, w_gap;
    logic [SW-1:0] w_gap_x;
    logic [FW-1:0] w_dist;

    // Input decode and range checks
    assign w_a_x  = XW'(i_in.data.node);
    assign w_b_x  = XW'(i_in.data.other_node);
    assign w_a_ok = w_a_x < XW'(NODE_COUNT);
    assign w_b_ok = w_b_x < XW'(NODE_COUNT);
    assign w_a    = w_a_x[NW-1:0];
    assign w_b    = w_b_x[NW-1:0];
    assign w_att_ok = w_a_ok && w_b_ok && (w_a != t_node'(SENTINEL_NODE))
                      && (w_a != t_node'(ROOT_NODE));

    // Attach level step; a row that is the child itself reads as the child
    assign w_new = (r_cur == r_c) ? r_c : r_rd_a.anc[r_lvl - LW'(1)];
    assign w_sat = (r_rd_a.depth >= t_node'(NODE_COUNT - 1)) ? t_node'(NODE_COUNT - 1)
                                                             : r_rd_a.depth + t_node'(1);

    // Highest remaining lift bit
    always_comb begin
        w_top = '0;
        for (int i = 0; i < KW; i++) begin
            if (r_k[i]) begin
                w_top = LW'(i);
            end
        end
    end

    assign w_lift = r_rd_a.anc[w_top];

    // Path length from the ancestor depth, clamped to the field range
    assign w_twice = {r_rd_a.depth, 1'b0};
    assign w_gap   = (r_sum > w_twice) ? r_sum - w_twice : '0;
    assign w_gap_x = SW'(w_gap);
    assign w_dist  = (w_gap_x > SW'(FIELD_MAX)) ? FIELD_MAX : w_gap_x[FW-1:0];
    assign w_lca_x = XW'(r_lca);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_c         = r_c;
        n_cur       = r_cur;
        n_lvl       = r_lvl;
        n_row       = r_row;
        n_v         = r_v;
        n_w         = r_w;
        n_k         = r_k;
        n_sum       = r_sum;
        n_lca       = r_lca;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_wa        = r_c;
        w_wd        = r_row;
        w_re_a      = 1'b0;
        w_ra_a      = r_v;
        w_re_b      = 1'b0;
        w_ra_b      = r_w;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                w_wa  = r_clr;
                w_wd  = '0;
                n_clr = r_clr + t_node'(1);
                if (r_clr == t_node'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.data.operation == OP_ATTACH) begin
                        // Drop attaches to the sentinel, the root or out of range
                        if (w_att_ok) begin
                            n_c          = w_a;
                            n_cur        = w_b;
                            n_lvl        = LW'(1);
                            n_row.anc[0] = w_b;
                            w_re_a       = 1'b1;
                            w_ra_a       = w_b;
                            n_state      = S_ATT;
                        end
                    end else if (w_a_ok && w_b_ok) begin
                        n_v     = w_a;
                        n_w     = w_b;
                        w_re_a  = 1'b1;
                        w_ra_a  = w_a;
                        w_re_b  = 1'b1;
                        w_ra_b  = w_b;
                        n_state = S_QLOAD;
                    end else begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_ATT: begin
                n_row.anc[r_lvl] = w_new;
                if (r_lvl == LW'(1)) begin
                    n_row.depth = w_sat;
                end
                n_cur = w_new;
                if (r_lvl == LW'(LIFT_LEVELS)) begin
                    n_state = S_ATT_WR;
                end else begin
                    n_lvl  = r_lvl + LW'(1);
                    w_re_a = 1'b1;
                    w_ra_a = w_new;
                end
            end
            S_ATT_WR: begin
                w_we    = 1'b1;
                w_wa    = r_c;
                w_wd    = r_row;
                n_state = S_IDLE;
            end
            S_QLOAD: begin
                n_sum = {1'b0, r_rd_a.depth} + {1'b0, r_rd_b.depth};
                // Put the deeper node in v
                if (r_rd_a.depth < r_rd_b.depth) begin
                    n_v = r_w;
                    n_w = r_v;
                    n_k = KW'(r_rd_b.depth - r_rd_a.depth);
                end else begin
                    n_k = KW'(r_rd_a.depth - r_rd_b.depth);
                end
                w_re_a  = 1'b1;
                w_ra_a  = n_v;
                w_re_b  = 1'b1;
                w_ra_b  = n_w;
                n_state = S_LIFT;
            end
            S_LIFT: begin
                if (r_k != '0) begin
                    n_v        = w_lift;
                    n_k[w_top] = 1'b0;
                    w_re_a     = 1'b1;
                    w_ra_a     = w_lift;
                end else if (r_v == r_w) begin
                    n_lca   = r_v;
                    w_re_a  = 1'b1;
                    w_ra_a  = r_v;
                    n_state = S_DEPTH;
                end else begin
                    n_lvl   = LW'(LIFT_LEVELS);
                    n_state = S_CLIMB;
                end
            end
            S_CLIMB: begin
                // Climb both nodes while their ancestors differ; rows are held otherwise
                if (r_rd_a.anc[r_lvl] != r_rd_b.anc[r_lvl]) begin
                    n_v    = r_rd_a.anc[r_lvl];
                    n_w    = r_rd_b.anc[r_lvl];
                    w_re_a = 1'b1;
                    w_ra_a = r_rd_a.anc[r_lvl];
                    w_re_b = 1'b1;
                    w_ra_b = r_rd_b.anc[r_lvl];
                end
                if (r_lvl == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_lvl = r_lvl - LW'(1);
                end
            end
            S_FIN: begin
                n_lca   = r_rd_a.anc[0];
                w_re_a  = 1'b1;
                w_ra_a  = r_rd_a.anc[0];
                n_state = S_DEPTH;
            end
            S_DEPTH: begin
                n_res.distance        = w_dist;
                n_res.common_ancestor = w_lca_x[FW-1:0];
                n_state               = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register frees up
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Row memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re_a) begin
            r_rd_a <= r_mem[w_ra_a];
        end
        if (w_re_b) begin
            r_rd_b <= r_mem[w_ra_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c   <= n_c;
        r_cur <= n_cur;
        r_lvl <= n_lvl;
        r_row <= n_row;
        r_v   <= n_v;
        r_w   <= n_w;
        r_k   <= n_k;
        r_sum <= n_sum;
        r_lca <= n_lca;
        r_res <= n_res;
        r_out <= n_out;
    end

    `TDBL_ASSERT(a_out_from_done, $rose(r_out_valid), $past(r_state == S_DONE), "result beat raised outside the done state")
    `TDBL_ASSERT(a_att_target, r_state == S_ATT_WR, r_c != t_node'(SENTINEL_NODE) && r_c != t_node'(ROOT_NODE), "attach writes the sentinel or root row")
    `TDBL_ASSERT_NEXT(a_lift_bit, r_state == S_LIFT && r_k != '0, $countones(r_k) + 1 == $countones($past(r_k)), "lift step did not consume exactly one bit")
    `TDBL_ASSERT_NEXT(a_climb_step, r_state == S_CLIMB && r_lvl != '0, r_state == S_CLIMB && r_lvl + 1 == $past(r_lvl), "climb level did not step down by one")

endmodule
